@@ rtl/core/gbp_pkg.sv @@
`default_nettype none
package gbp_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int ADDR_W     = $clog2(PAGE_BYTES);
  localparam int PTR_W      = ADDR_W + 1;

  localparam logic [PTR_W-1:0] PAGE_SIZE = PTR_W'(PAGE_BYTES);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_POS  = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request fields
    logic check;     // latch status and read flags, read the text byte
    logic move_rd;   // read the byte crossing the gap
    logic move_wr;   // write it on the far side, shift the gap by one
    logic apply;     // insert or delete at the gap
    logic finish;    // load result registers
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;       // nothing to do beyond reporting
    logic is_read;
    logic gap_at_pos;
    logic step_last;  // this move step puts the gap at the position
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/gbp_ram.sv @@
`default_nettype none
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/gbp_datapath.sv @@
`default_nettype none
module gbp_datapath
  import gbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dp_cmd_t          dcmd,
  output dp_stat_t              dstat,
  input  wire logic [1:0]       cmd,
  input  wire logic [PTR_W-1:0] position,
  input  wire logic [7:0]       data_byte,
  input  wire logic [PTR_W-1:0] count,
  output logic      [7:0]       read_byte,
  output logic                  at_end,
  output logic      [PTR_W-1:0] used_bytes,
  output logic      [PTR_W-1:0] free_bytes,
  output logic      [1:0]       status
);

  logic [1:0]       cmd_r;
  logic [PTR_W-1:0] pos_r;
  logic [7:0]       data_r;
  logic [PTR_W-1:0] cnt_r;

  logic [PTR_W-1:0] gap_start;
  logic [PTR_W-1:0] gap_end;

  status_t          stat_r;
  logic             at_end_r;
  logic             read_ok_r;

  logic [PTR_W-1:0] gap_len;
  logic [PTR_W-1:0] size;
  logic             pos_bad;
  logic             full;
  logic             past_end;
  logic             move_right;
  status_t          stat_now;

  logic [PTR_W-1:0] text_idx;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  assign gap_len    = gap_end - gap_start;
  assign size       = PAGE_SIZE - gap_len;
  assign pos_bad    = pos_r > size;
  assign full       = gap_end == gap_start;
  assign past_end   = cnt_r > (size - pos_r);
  assign move_right = pos_r > gap_start;
  assign text_idx   = (pos_r >= gap_start) ? (pos_r + gap_len) : pos_r;

  always_comb begin
    stat_now = ST_OK;
    if (cmd_r != CMD_NONE && pos_bad) begin
      stat_now = ST_BAD_POS;
    end else if (cmd_r == CMD_INSERT && full) begin
      stat_now = ST_FULL;
    end else if (cmd_r == CMD_DELETE && past_end) begin
      stat_now = ST_PAST_END;
    end
  end

  always_comb begin
    dstat.skip       = (stat_now != ST_OK) || (cmd_r == CMD_NONE) ||
                       (cmd_r == CMD_READ && pos_r == size);
    dstat.is_read    = cmd_r == CMD_READ;
    dstat.gap_at_pos = gap_start == pos_r;
    dstat.step_last  = move_right ? (gap_start + PTR_W'(1) == pos_r)
                                  : (gap_start - PTR_W'(1) == pos_r);
  end

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = gap_start[ADDR_W-1:0];
    ram_wdata = data_r;
    ram_raddr = text_idx[ADDR_W-1:0];
    if (dcmd.move_rd) begin
      ram_raddr = move_right ? gap_end[ADDR_W-1:0]
                             : ADDR_W'(gap_start - PTR_W'(1));
    end
    if (dcmd.move_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      ram_waddr = move_right ? gap_start[ADDR_W-1:0]
                             : ADDR_W'(gap_end - PTR_W'(1));
    end
    if (dcmd.apply && cmd_r == CMD_INSERT) begin
      ram_we = 1'b1;
    end
  end

  gbp_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_page (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      cmd_r  <= cmd;
      pos_r  <= position;
      data_r <= data_byte;
      cnt_r  <= count;
    end
    if (dcmd.check) begin
      stat_r    <= stat_now;
      at_end_r  <= cmd_r == CMD_READ && !pos_bad && pos_r == size;
      read_ok_r <= cmd_r == CMD_READ && !pos_bad && pos_r != size;
    end
    if (dcmd.finish) begin
      read_byte  <= read_ok_r ? ram_rdata : 8'd0;
      at_end     <= at_end_r;
      used_bytes <= size;
      free_bytes <= gap_len;
      status     <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_start <= '0;
      gap_end   <= PAGE_SIZE;
    end else if (dcmd.move_wr) begin
      if (move_right) begin
        gap_start <= gap_start + PTR_W'(1);
        gap_end   <= gap_end + PTR_W'(1);
      end else begin
        gap_start <= gap_start - PTR_W'(1);
        gap_end   <= gap_end - PTR_W'(1);
      end
    end else if (dcmd.apply) begin
      if (cmd_r == CMD_INSERT) begin
        gap_start <= gap_start + PTR_W'(1);
      end else begin
        gap_end <= gap_end + cnt_r;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gbp_ctrl.sv @@
`default_nettype none
module gbp_ctrl
  import gbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  output logic          done,
  output dp_cmd_t       dcmd,
  input  wire dp_stat_t dstat
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_MOVE_RD = 6'b000100,
    S_MOVE_WR = 6'b001000,
    S_APPLY   = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    dcmd       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          dcmd.load  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        dcmd.check = 1'b1;
        if (dstat.skip) begin
          state_next = S_FINISH;
        end else if (dstat.is_read) begin
          // text byte is read from the page in this cycle
          state_next = S_FINISH;
        end else if (dstat.gap_at_pos) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        dcmd.move_rd = 1'b1;
        state_next   = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        dcmd.move_wr = 1'b1;
        state_next   = dstat.step_last ? S_APPLY : S_MOVE_RD;
      end
      S_APPLY: begin
        dcmd.apply = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        dcmd.finish = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= dcmd.finish;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gap_buffer_page_core.sv @@
`default_nettype none
// One page of a text gap buffer: 4096 bytes of storage with one gap.
// Request channel: cmd, position, data_byte, count are taken at a rising
// edge with start high and busy low. cmd selects insert one byte, delete
// count bytes, or read one byte; cmd 3 is a no-op that still reports.
// Result channel: done is high for exactly one cycle while read_byte,
// at_end, used_bytes, free_bytes and status hold the result; the receiver
// cannot stall, so nothing waits and nothing backs up.
// Sequence: a read or a rejected request goes from accept through check
// to finish; an edit that lands at the gap goes through check, apply and
// finish. An edit away from the gap first walks the gap there one byte
// per step (one page RAM read, then one write), then applies and finishes.
// busy drops in the cycle done rises, so a new request can be accepted
// there; one request is in flight at a time.
// Bad positions, page full and delete past end are reported in status and
// leave the page untouched.
// Reset (rst, synchronous): gap covers the whole page, text is empty.
// Page contents are not cleared; only written bytes are ever read back.
module gap_buffer_page_core
  import gbp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [PTR_W-1:0] position,
  input  wire logic [7:0]       data_byte,
  input  wire logic [PTR_W-1:0] count,
  output logic                  done,
  output logic      [7:0]       read_byte,
  output logic                  at_end,
  output logic      [PTR_W-1:0] used_bytes,
  output logic      [PTR_W-1:0] free_bytes,
  output logic      [1:0]       status
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // sequencer: check, gap walk, apply, report
  gbp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .dcmd (dcmd),
    .dstat(dstat)
  );

  // gap pointers, page RAM and result registers
  gbp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .dcmd      (dcmd),
    .dstat     (dstat),
    .cmd       (cmd),
    .position  (position),
    .data_byte (data_byte),
    .count     (count),
    .read_byte (read_byte),
    .at_end    (at_end),
    .used_bytes(used_bytes),
    .free_bytes(free_bytes),
    .status    (status)
  );

endmodule
`default_nettype wire
